@@ sv/jrm_pkg.sv @@
// ----------------------------------------------------------------------------
// jrm_pkg: shared types and codes for the key exchange round block
// step codes and the control struct between sequencer and modular multiplier
// ----------------------------------------------------------------------------
`default_nettype none

package jrm_pkg;

    localparam logic [1:0] ACT_LOAD_OWN = 2'd0;
    localparam logic [1:0] ACT_PARTNER  = 2'd1;
    localparam logic [1:0] ACT_STEP_TWO = 2'd2;

    localparam logic [1:0] CFG_MODULUS   = 2'd0;
    localparam logic [1:0] CFG_GENERATOR = 2'd1;
    localparam logic [1:0] CFG_SECRET    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_G,      // reduce generator mod p
        ST_PRE,        // prepare a power
        ST_MUL_START,  // launch one multiply
        ST_MUL_WAIT,
        ST_POW_NEXT,   // advance exponent bit
        ST_POW_DONE,
        ST_OUT
    } t_state;

    // request to the bit-serial modular multiplier
    typedef struct packed {
        logic start;
    } t_mul_ctrl;

endpackage

`default_nettype wire

@@ sv/jpake_round_modexp.sv @@
// ----------------------------------------------------------------------------
// jpake_round_modexp: one party of a password key exchange round
// square-and-multiply modular powers over a bit-serial modular multiplier
// ----------------------------------------------------------------------------
//  channel   dir  content
//  s_axis    in   action, exponent_first, exponent_second
//  m_axis    out  result_first, result_second
//  cfg       in   modulus, generator, shared_secret (index 0..2)
//
//  each multiply step is launch, a run of the shared serial multiplier and
//  advance; g mod p and b*secret are built side by side in the reduction state
//  a power of an exponent with k significant bits costs 2k+1 multiplies
//  (3 for a zero exponent) plus the prepare and done states; action 1 runs
//  two powers of EXP_WIDTH bits, action 2 one of EXP_WIDTH, two single
//  products and one of 2*EXP_WIDTH bits; action 0 and the undefined
//  action 3 go straight to the output
//  one request at a time; the result register holds while the output stalls
//  reset is synchronous and clears the stored exponents and commitments
`default_nettype none

module jpake_round_modexp
    import jrm_pkg::*;
#(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // tdata: action[1:0], exponent_first, exponent_second, zero fill
    input  wire logic [((2+2*EXP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: result_first[31:0], result_second[63:32]
    output logic [63:0]                 m_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic                   i_cfg_we,
    input  wire logic [1:0]             i_cfg_index,
    input  wire logic [MOD_WIDTH-1:0]   i_cfg_data
);

    localparam int EW2 = 2 * EXP_WIDTH;
    localparam int BW  = $clog2(EW2 + 1);
    localparam int RW  = $clog2(MOD_WIDTH + 1);
    localparam int SW  = $clog2(EXP_WIDTH + 1);

    // configuration
    logic [MOD_WIDTH-1:0] r_mod, r_gen;
    logic [EXP_WIDTH-1:0] r_secret;

    // round state
    logic [EXP_WIDTH-1:0] r_a, r_b, r_c, r_d;
    logic [MOD_WIDTH-1:0] r_cc, r_cd;

    // sequencer
    t_state r_state, n_state;
    logic [1:0]           r_act;
    logic [2:0]           r_phase;   // which power / multiply of the step
    logic [MOD_WIDTH-1:0] r_gred;    // g mod p
    logic [MOD_WIDTH-1:0] r_base, r_pacc;
    logic [EW2-1:0]       r_exp;
    logic [BW-1:0]        r_bits;
    logic                 r_sq;      // current multiply is the squaring
    logic [MOD_WIDTH-1:0] r_t0;      // saved power
    logic [MOD_WIDTH-1:0] r_res1, r_res2;
    logic                 r_oval;

    // product b*secret, built one secret bit per cycle during the g reduction
    logic [EW2-1:0]       r_eprod;
    logic [EXP_WIDTH-1:0] r_sec_sh;
    logic [SW-1:0]        r_ecnt;

    t_mul_ctrl            w_mctl;
    logic [MOD_WIDTH-1:0] w_mx, w_my, w_prod;
    logic                 w_mdone;
    logic                 w_in_acc;
    logic [1:0]           w_act;
    logic [EXP_WIDTH-1:0] w_e1, w_e2;
    logic [MOD_WIDTH-1:0] w_pval;

    assign w_act = s_axis_tdata[1:0];
    assign w_e1  = s_axis_tdata[2 +: EXP_WIDTH];
    assign w_e2  = s_axis_tdata[2+EXP_WIDTH +: EXP_WIDTH];
    assign s_axis_tready = (r_state == ST_IDLE) && !r_oval;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // zero modulus: every modular value is 0
    assign w_pval = (r_mod == '0) ? '0 : r_pacc;

    jrm_modmul #(.MOD_WIDTH(MOD_WIDTH)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_mctl),
        .i_x    (w_mx),
        .i_y    (w_my),
        .i_m    (r_mod),
        .o_done (w_mdone),
        .o_prod (w_prod)
    );

    // g mod p by restoring subtraction, one bit a cycle
    logic [MOD_WIDTH:0]   r_rem;
    logic [MOD_WIDTH-1:0] r_rq;
    logic [RW-1:0]        r_rcnt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (w_in_acc) begin
                              if (w_act == ACT_PARTNER || w_act == ACT_STEP_TWO)
                                  n_state = ST_RED_G;
                              else
                                  n_state = ST_OUT;
                          end
            ST_RED_G:     if (r_rcnt == '0 && r_ecnt == '0) n_state = ST_PRE;
            ST_PRE:       n_state = ST_MUL_START;
            ST_MUL_START: n_state = ST_MUL_WAIT;
            ST_MUL_WAIT:  if (w_mdone) n_state = ST_POW_NEXT;
            ST_POW_NEXT:  n_state = (!r_sq && r_bits == '0) ? ST_POW_DONE
                                                           : ST_MUL_START;
            ST_POW_DONE:  n_state = ST_PRE;
            ST_OUT:       n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
        // the done state decides whether the step is over
        if (r_state == ST_POW_DONE &&
            ((r_act == ACT_PARTNER && r_phase == 3'd1) ||
             (r_act == ACT_STEP_TWO && r_phase == 3'd4)))
            n_state = ST_OUT;
    end

    // multiplier launch; the step-two products reuse the power datapath
    always_comb begin
        w_mctl.start = (r_state == ST_MUL_START);
        if (r_sq) begin
            w_mx = r_base;
            w_my = r_base;
        end else begin
            w_mx = r_pacc;
            w_my = r_base;
        end
    end

    // 1 mod m, the start value of every power but the two step-two products
    function automatic logic [MOD_WIDTH-1:0] f_one(input logic [MOD_WIDTH-1:0] m);
        return (m == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
    endfunction

    logic [MOD_WIDTH:0] w_rsh;
    assign w_rsh = {r_rem[MOD_WIDTH-1:0], r_rq[MOD_WIDTH-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mod    <= MOD_WIDTH'(3);
            r_gen    <= MOD_WIDTH'(2);
            r_secret <= '0;
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0;
            r_cc <= '0; r_cd <= '0;
            r_oval   <= 1'b0;
            r_phase  <= '0;
            r_act    <= ACT_LOAD_OWN;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODULUS:   r_mod    <= i_cfg_data;
                    CFG_GENERATOR: r_gen    <= i_cfg_data;
                    CFG_SECRET:    r_secret <= i_cfg_data[EXP_WIDTH-1:0];
                    default:       ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) r_oval <= 1'b0;
            case (r_state)
                ST_IDLE: if (w_in_acc) begin
                    r_act    <= w_act;
                    r_phase  <= '0;
                    r_res1   <= '0;
                    r_res2   <= '0;
                    r_rem    <= '0;
                    r_rq     <= r_gen;
                    r_rcnt   <= RW'(MOD_WIDTH);
                    r_eprod  <= '0;
                    r_sec_sh <= r_secret;
                    r_ecnt   <= SW'(EXP_WIDTH);
                    if (w_act == ACT_LOAD_OWN) begin
                        r_a <= w_e1; r_b <= w_e2;
                    end else if (w_act == ACT_PARTNER) begin
                        r_c <= w_e1; r_d <= w_e2;
                    end
                end
                ST_RED_G: begin
                    if (r_rcnt != '0) begin
                        r_rcnt <= r_rcnt - 1'b1;
                        r_rq   <= r_rq << 1;
                        if (w_rsh >= {1'b0, r_mod})
                            r_rem <= w_rsh - {1'b0, r_mod};
                        else
                            r_rem <= w_rsh;
                    end else begin
                        r_gred <= (r_mod == '0) ? '0 : r_rem[MOD_WIDTH-1:0];
                    end
                    // b*secret, secret msb first
                    if (r_ecnt != '0) begin
                        r_ecnt   <= r_ecnt - 1'b1;
                        r_sec_sh <= r_sec_sh << 1;
                        r_eprod  <= (r_eprod << 1) +
                                    (r_sec_sh[EXP_WIDTH-1] ? EW2'(r_b) : '0);
                    end
                end
                ST_PRE: begin
                    r_sq   <= 1'b0;
                    r_bits <= BW'(EW2);
                    case (r_phase)
                        3'd0: begin
                            r_pacc <= f_one(r_mod);
                            r_base <= r_gred;
                            r_exp  <= (r_act == ACT_PARTNER) ? EW2'(r_c) : EW2'(r_a);
                        end
                        3'd1: begin
                            r_pacc <= f_one(r_mod);
                            r_base <= r_gred;
                            r_exp  <= EW2'(r_d);
                        end
                        // t0 * C then * D: run as powers with exponent one;
                        // a commitment not below p feeds only the serial operand of the product that is kept
                        3'd2: begin
                            r_pacc <= r_t0;
                            r_base <= r_cc;
                            r_exp  <= EW2'(1);
                        end
                        3'd3: begin
                            r_pacc <= r_t0;
                            r_base <= r_cd;
                            r_exp  <= EW2'(1);
                        end
                        default: begin
                            r_pacc <= f_one(r_mod);
                            r_base <= r_t0;
                            r_exp  <= r_eprod;
                        end
                    endcase
                end
                ST_MUL_START: ;
                ST_MUL_WAIT: if (w_mdone) begin
                    if (r_sq) r_base <= w_prod;
                    else if (r_exp[0]) r_pacc <= w_prod;
                end
                ST_POW_NEXT: begin
                    if (r_sq) begin
                        r_sq  <= 1'b0;
                        r_exp <= r_exp >> 1;
                        r_bits <= (r_exp[EW2-1:1] == '0) ? '0 : r_bits - 1'b1;
                    end else begin
                        r_sq <= 1'b1;
                    end
                end
                ST_POW_DONE: begin
                    // step two skips the partner power and goes to the C product
                    r_phase <= (r_act == ACT_STEP_TWO && r_phase == 3'd0) ? 3'd2
                                                                         : r_phase + 3'd1;
                    case (r_phase)
                        3'd0: begin
                            if (r_act == ACT_PARTNER) begin
                                r_cc <= w_pval; r_res1 <= w_pval;
                            end else r_t0 <= w_pval;
                        end
                        3'd1: begin
                            if (r_act == ACT_PARTNER) begin
                                r_cd <= w_pval; r_res2 <= w_pval;
                            end else r_t0 <= w_pval;
                        end
                        3'd2, 3'd3: r_t0 <= w_pval;
                        default: r_res1 <= w_pval;
                    endcase
                end
                ST_OUT: r_oval <= 1'b1;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {32'(r_res2), 32'(r_res1)};

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> m_axis_tvalid) else $error("result lost");
`endif

endmodule

`default_nettype wire

@@ sv/jrm_modmul.sv @@
// ----------------------------------------------------------------------------
// jrm_modmul: bit-serial modular multiplier
// shift-and-add x*y mod m, one multiplier bit per cycle, operands below m
// ----------------------------------------------------------------------------
`default_nettype none

module jrm_modmul
    import jrm_pkg::*;
#(
    parameter int MOD_WIDTH = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_mul_ctrl            i_ctrl,
    input  wire logic [MOD_WIDTH-1:0] i_x,
    input  wire logic [MOD_WIDTH-1:0] i_y,
    input  wire logic [MOD_WIDTH-1:0] i_m,
    output logic                      o_done,
    output logic [MOD_WIDTH-1:0]      o_prod
);

    localparam int CW = $clog2(MOD_WIDTH + 1);

    logic [MOD_WIDTH-1:0] r_x, r_y, r_acc;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy, r_done;
    logic [MOD_WIDTH-1:0] w_sum, w_dbl;

    // (a + b) mod m for a, b < m without overflow
    function automatic logic [MOD_WIDTH-1:0] f_add(
        input logic [MOD_WIDTH-1:0] a,
        input logic [MOD_WIDTH-1:0] b,
        input logic [MOD_WIDTH-1:0] m
    );
        logic [MOD_WIDTH-1:0] room;
        room = m - b;
        return (a >= room) ? a - room : a + b;
    endfunction

    assign w_sum = f_add(r_acc, r_x, i_m);
    assign w_dbl = f_add(r_x, r_x, i_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MOD_WIDTH);
            end else if (r_busy) begin
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_y[0]) r_acc <= w_sum;
            r_x <= w_dbl;
            r_y <= r_y >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_ctrl.start) else $error("multiply restarted while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done longer than one cycle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
`endif

endmodule

`default_nettype wire
